@@ hdl/pss_zc_pkg.sv @@
package pss_zc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_BINS    = 2048;
  localparam int HALF_LEN    = 31;
  localparam int TAB_DEPTH   = 64;

  localparam logic [1:0] CFG_CELL_IDENTITY = 2'd0;
  localparam logic [1:0] CFG_FFT_SIZE      = 2'd1;
  localparam logic [1:0] CFG_RECEIVE_MODE  = 2'd2;

  localparam longint unsigned PI_Q32    = 64'd13493037705;
  localparam longint unsigned PHASE_MOD = 64'd126;
  localparam longint          SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam int              ROUND_SHIFT = 31 - SAMPLE_BITS;

  // (2i-1)(2i) for the cosine series terms
  localparam longint unsigned TAYLOR_DIV [1:12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  typedef logic [SAMPLE_BITS-2:0] mag_t;
  typedef mag_t cos_tab_t [TAB_DEPTH];

  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [11:0] m;
  } m_word_t;

  typedef struct packed {
    logic       vld;
    logic       hit;
    logic [4:0] h;
    logic       negc;
    logic       negs;
  } phase_word_t;

  // cos(pi*j/126), j = 0..63, Q1.(SAMPLE_BITS-1), saturated
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t          tab;
    longint unsigned   x32;
    longint unsigned   x30;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            r;
    for (int j = 0; j < TAB_DEPTH; j++) begin
      x32  = (PI_Q32 * longint'(j) + 64'd63) / PHASE_MOD;
      x30  = (x32 + 64'd2) >> 2;
      x2   = (x30 * x30) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int i = 1; i <= 12; i++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[i];
        if (i % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (r > SAMPLE_MAX) begin
        r = SAMPLE_MAX;
      end
      tab[j] = mag_t'(r);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  // x mod 126 for x below 8192: reciprocal estimate plus one correction
  function automatic logic [6:0] mod_126(input logic [12:0] x);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [13:0] qm;
    logic [12:0] r;
    prod = 23'(x) * 23'd520;
    q    = prod[22:16];
    qm   = 14'(q) * 14'd126;
    r    = x - qm[12:0];
    if (r >= 13'd126) begin
      r = r - 13'd126;
    end
    return r[6:0];
  endfunction

  function automatic logic [5:0] root_of(input logic [1:0] cell_identity);
    logic [5:0] root;
    case (cell_identity)
      2'd0:    root = 6'd25;
      2'd1:    root = 6'd29;
      default: root = 6'd34;
    endcase
    return root;
  endfunction

endpackage

@@ hdl/pss_zc_index.sv @@
module pss_zc_index #(
  parameter int MAX_BINS = pss_zc_pkg::MAX_BINS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [10:0]          bin_i,
  input  logic [11:0]          fft_size_i,
  output pss_zc_pkg::m_word_t  m_o
);

  localparam logic [12:0] MaxBins = 13'(MAX_BINS);
  localparam logic [12:0] HalfLen = 13'(pss_zc_pkg::HALF_LEN);

  logic                s1_vld_q, s1_vld_d;
  logic                s1_hit_q, s1_hit_d;
  logic [5:0]          s1_n_q, s1_n_d;
  pss_zc_pkg::m_word_t m_q, m_d;

  logic [12:0] fs;
  logic [12:0] b;
  logic [12:0] lo_edge;
  logic [12:0] n_hi;
  logic        in_range;
  logic [6:0]  a;
  logic [13:0] prod;

  always_comb begin
    fs       = ({1'b0, fft_size_i} > MaxBins) ? MaxBins : {1'b0, fft_size_i};
    b        = {2'b00, bin_i};
    lo_edge  = fs - HalfLen;
    n_hi     = b - lo_edge;
    in_range = (b >= 13'd1) && (b < fs);
    s1_vld_d = vld_i;
    s1_hit_d = 1'b0;
    s1_n_d   = '0;
    if (in_range && (b <= HalfLen)) begin
      s1_hit_d = 1'b1;
      s1_n_d   = 6'(b + HalfLen - 13'd1);
    end else if (in_range && (fs >= HalfLen) && (b >= lo_edge)) begin
      s1_hit_d = 1'b1;
      s1_n_d   = n_hi[5:0];
    end
  end

  // element index to m: n(n+1) below the punctured centre, (n+1)(n+2) above
  always_comb begin
    a       = (s1_n_q < 6'(pss_zc_pkg::HALF_LEN)) ? {1'b0, s1_n_q} : {1'b0, s1_n_q} + 7'd1;
    prod    = a * (a + 7'd1);
    m_d.vld = s1_vld_q;
    m_d.hit = s1_hit_q;
    m_d.m   = prod[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      m_q      <= '0;
    end else if (en_i) begin
      s1_vld_q <= s1_vld_d;
      m_q      <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_hit_q <= s1_hit_d;
      s1_n_q   <= s1_n_d;
    end
  end

  assign m_o = m_q;

endmodule

@@ hdl/pss_zc_phase.sv @@
module pss_zc_phase (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  pss_zc_pkg::m_word_t     m_i,
  input  logic [1:0]              cell_identity_i,
  input  logic                    receive_mode_i,
  output pss_zc_pkg::phase_word_t phase_o
);

  logic        s3_vld_q, s3_hit_q;
  logic [6:0]  s3_k1_q, s3_k1_d;
  logic        s4_vld_q, s4_hit_q;
  logic [12:0] s4_p_q, s4_p_d;
  pss_zc_pkg::phase_word_t ph_q, ph_d;

  logic [6:0] k;
  logic [6:0] k2;
  logic [5:0] h;
  logic       negs;
  logic       negc;

  assign s3_k1_d = pss_zc_pkg::mod_126({1'b0, m_i.m});
  assign s4_p_d  = 13'(s3_k1_q) * 13'(pss_zc_pkg::root_of(cell_identity_i));

  // fold the 126-point phase onto a quarter wave
  always_comb begin
    k        = pss_zc_pkg::mod_126(s4_p_q);
    negs     = k > 7'd63;
    k2       = negs ? 7'd126 - k : k;
    negc     = k2 > 7'd31;
    h        = negc ? 6'd63 - k2[5:0] : k2[5:0];
    ph_d.vld  = s4_vld_q;
    ph_d.hit  = s4_hit_q;
    ph_d.h    = h[4:0];
    ph_d.negc = negc;
    ph_d.negs = negs ^ ~receive_mode_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      ph_q     <= '0;
    end else if (en_i) begin
      s3_vld_q <= m_i.vld;
      s4_vld_q <= s3_vld_q;
      ph_q     <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_hit_q  <= m_i.hit;
      s3_k1_q   <= s3_k1_d;
      s4_hit_q  <= s3_hit_q;
      s4_p_q    <= s4_p_d;
    end
  end

  assign phase_o = ph_q;

endmodule

@@ hdl/pss_zc_lut.sv @@
module pss_zc_lut (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  pss_zc_pkg::phase_word_t               phase_i,
  output logic                                  vld_o,
  output logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] real_o,
  output logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] imag_o,
  output logic                                  hit_o
);

  logic                                      vld_q;
  logic                                      hit_q;
  logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] re_q, re_d;
  logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] im_q, im_d;

  logic [5:0]                                j_re;
  logic [5:0]                                j_im;
  logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] re_pos;
  logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] im_pos;

  // cosine at 2h, sine at 63-2h of the half-step table
  always_comb begin
    j_re   = {phase_i.h, 1'b0};
    j_im   = {~phase_i.h, 1'b1};
    re_pos = $signed({1'b0, pss_zc_pkg::COS_TAB[j_re]});
    im_pos = $signed({1'b0, pss_zc_pkg::COS_TAB[j_im]});
    re_d   = '0;
    im_d   = '0;
    if (phase_i.hit) begin
      re_d = phase_i.negc ? -re_pos : re_pos;
      im_d = phase_i.negs ? -im_pos : im_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= phase_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= phase_i.hit;
      re_q  <= re_d;
      im_q  <= im_d;
    end
  end

  assign vld_o  = vld_q;
  assign real_o = re_q;
  assign imag_o = im_q;
  assign hit_o  = hit_q;

endmodule

@@ hdl/lte_pss_zadoff_chu_bin_generator.sv @@
// Pipeline: six register stages between the bin input and the shown word.
// Throughput: one bin per cycle; the whole pipe holds while a shown word is stalled.
// Reset (asynchronous, active low) empties the pipe and sets cell identity 0,
// FFT size 128 and transmit mode.
module lte_pss_zadoff_chu_bin_generator #(
  parameter int MAX_BINS = pss_zc_pkg::MAX_BINS
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [10:0]                               bin_index_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] real_value_o,
  output logic signed [pss_zc_pkg::SAMPLE_BITS-1:0] imag_value_o,
  output logic                                      carries_pss_o,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [1:0]                                cfg_index_i,
  input  logic [11:0]                               cfg_data_i
);

  logic [1:0]  cell_identity_q;
  logic [11:0] fft_size_q;
  logic        receive_mode_q;
  logic        en;

  pss_zc_pkg::m_word_t     m_word;
  pss_zc_pkg::phase_word_t phase_word;

  assign cfg_ready_o = 1'b1;
  assign en          = ~out_valid_o | ~out_stall_i;
  assign in_stall_o  = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_identity_q <= 2'd0;
      fft_size_q      <= 12'd128;
      receive_mode_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pss_zc_pkg::CFG_CELL_IDENTITY: cell_identity_q <= cfg_data_i[1:0];
        pss_zc_pkg::CFG_FFT_SIZE:      fft_size_q      <= cfg_data_i;
        pss_zc_pkg::CFG_RECEIVE_MODE:  receive_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pss_zc_index #(
    .MAX_BINS(MAX_BINS)
  ) u_index (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (in_valid_i),
    .bin_i     (bin_index_i),
    .fft_size_i(fft_size_q),
    .m_o       (m_word)
  );

  pss_zc_phase u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .m_i            (m_word),
    .cell_identity_i(cell_identity_q),
    .receive_mode_i (receive_mode_q),
    .phase_o        (phase_word)
  );

  pss_zc_lut u_lut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .phase_i(phase_word),
    .vld_o  (out_valid_o),
    .real_o (real_value_o),
    .imag_o (imag_value_o),
    .hit_o  (carries_pss_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int PHASES      = 10;
  localparam int RAND_ITEMS  = 123;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;
  localparam int BAND        = 31;
  localparam int BIN_CAP     = 2048;

  localparam longint unsigned PI_FX32   = 64'd13493037705;
  localparam longint unsigned TURN_STEP = 64'd126;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               pss;
  } pss_bin_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_pattern_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [10:0] bin_index_i   = '0;
  logic        out_stall_i   = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [1:0]  cfg_index_i   = pss_zc_pkg::CFG_CELL_IDENTITY;
  logic [11:0] cfg_data_i    = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic signed [15:0] real_value_o;
  logic signed [15:0] imag_value_o;
  logic        carries_pss_o;
  logic        cfg_ready_o;

  logic [1:0]  cur_cell = 2'd0;
  logic [11:0] cur_fft  = 12'd128;
  logic        cur_rx   = 1'b0;

  int          cos_mag [64];
  logic [10:0] pending_bins [$];
  pss_bin_t    expected_bins [$];
  int          mismatches   = 0;
  int          cycles       = 0;
  bit          bin_accepted = 1'b0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;
  stall_pattern_e stall_mode = STALL_NONE;

  lte_pss_zadoff_chu_bin_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .bin_index_i   (bin_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .real_value_o  (real_value_o),
    .imag_value_o  (imag_value_o),
    .carries_pss_o (carries_pss_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // cos(pi*j/126) in Q1.15 via a fixed-point Taylor series, saturated at 32767
  function automatic int cos_q15(input int j);
    longint unsigned ang32;
    longint unsigned ang30;
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    longint          r;
    ang32 = (PI_FX32 * longint'(j) + 64'd63) / TURN_STEP;
    ang30 = (ang32 + 64'd2) >> 2;
    sq    = (ang30 * ang30) >> 30;
    term  = 64'd1 << 30;
    acc   = longint'(term);
    for (int i = 1; i <= 12; i++) begin
      term = ((term * sq) >> 30) / longint'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc + (64'sd1 <<< 14)) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return int'(r);
  endfunction

  function automatic pss_bin_t predict_bin(input logic [10:0] bin);
    pss_bin_t res;
    int  fs;
    int  b;
    int  n;
    int  root;
    int  m;
    int  k;
    int  h;
    int  re;
    int  im;
    bit  hit;
    bit  neg_cos;
    bit  neg_sin;
    fs  = (cur_fft > BIN_CAP) ? BIN_CAP : int'(cur_fft);
    b   = int'(bin);
    n   = 0;
    hit = 1'b0;
    if (b >= 1 && b <= BAND && b < fs) begin
      n   = BAND + b - 1;
      hit = 1'b1;
    end else if (b >= 1 && fs >= BAND && b < fs && b >= fs - BAND) begin
      n   = b - (fs - BAND);
      hit = 1'b1;
    end
    res.re  = '0;
    res.im  = '0;
    res.pss = 1'b0;
    if (hit) begin
      case (cur_cell)
        2'd0:    root = 25;
        2'd1:    root = 29;
        default: root = 34;
      endcase
      m = (n < BAND) ? n * (n + 1) : (n + 1) * (n + 2);
      k = (root * m) % 126;
      neg_sin = 1'b0;
      if (k > 63) begin
        k       = 126 - k;
        neg_sin = 1'b1;
      end
      neg_cos = (k > 31);
      h  = neg_cos ? 63 - k : k;
      re = cos_mag[2 * h];
      im = cos_mag[63 - 2 * h];
      if (neg_cos) begin
        re = -re;
      end
      if (!cur_rx) begin
        neg_sin = !neg_sin;
      end
      if (neg_sin) begin
        im = -im;
      end
      res.re  = 16'(re);
      res.im  = 16'(im);
      res.pss = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [10:0] pick_bin();
    int fs;
    int sel;
    fs  = (cur_fft > BIN_CAP) ? BIN_CAP : int'(cur_fft);
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return 11'($urandom_range(1, BAND));
    end else if (sel < 7 && fs > BAND) begin
      return 11'(fs - $urandom_range(1, BAND));
    end else if (sel < 9 && fs > 0) begin
      return 11'($urandom_range(0, fs - 1));
    end
    return 11'($urandom_range(0, 2047));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pss_zc_pkg::CFG_CELL_IDENTITY: cur_cell = val[1:0];
      pss_zc_pkg::CFG_FFT_SIZE:      cur_fft  = val;
      pss_zc_pkg::CFG_RECEIVE_MODE:  cur_rx   = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_bins.size() != 0 || in_valid_i || expected_bins.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // sender: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || bin_accepted)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_bins.size() > 0) begin
        bin_index_i <= pending_bins.pop_front();
        in_valid_i  <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall patterns
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_pattern_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_SPARSE:   out_stall_i <= ($urandom_range(0, 9) < 3);
      STALL_PERIODIC: out_stall_i <= (stall_left % 3 == 0);
      default:        out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk_i) begin : monitor
    pss_bin_t want;
    bin_accepted = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        bin_accepted = 1'b1;
        expected_bins.push_back(predict_bin(bin_index_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: re %0d im %0d pss %0b",
                     real_value_o, imag_value_o, carries_pss_o);
          end
        end else begin
          want = expected_bins.pop_front();
          if (real_value_o !== want.re || imag_value_o !== want.im ||
              carries_pss_o !== want.pss) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch: exp re %0d im %0d pss %0b, got re %0d im %0d pss %0b",
                       want.re, want.im, want.pss,
                       real_value_o, imag_value_o, carries_pss_o);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [10:0] directed [$];
    directed = '{11'd0, 11'd1, 11'd2, 11'd15, 11'd30, 11'd31, 11'd32, 11'd33,
                 11'd63, 11'd64, 11'd95, 11'd96, 11'd97, 11'd98, 11'd120, 11'd126,
                 11'd127, 11'd128, 11'd1024, 11'd2047};
    for (int j = 0; j < 64; j++) begin
      cos_mag[j] = cos_q15(j);
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: begin
            write_reg(pss_zc_pkg::CFG_CELL_IDENTITY, 12'd1);
            write_reg(pss_zc_pkg::CFG_FFT_SIZE, 12'd2048);
            write_reg(pss_zc_pkg::CFG_RECEIVE_MODE, 12'd1);
          end
          2: begin
            write_reg(pss_zc_pkg::CFG_CELL_IDENTITY, 12'd2);
            write_reg(pss_zc_pkg::CFG_FFT_SIZE, 12'd4095);
            write_reg(pss_zc_pkg::CFG_RECEIVE_MODE, 12'd0);
          end
          3: begin
            write_reg(pss_zc_pkg::CFG_CELL_IDENTITY, 12'd3);
            write_reg(pss_zc_pkg::CFG_FFT_SIZE, 12'd63);
            write_reg(pss_zc_pkg::CFG_RECEIVE_MODE, 12'd1);
          end
          4: begin
            write_reg(pss_zc_pkg::CFG_CELL_IDENTITY, 12'd0);
            write_reg(pss_zc_pkg::CFG_FFT_SIZE, 12'd40);
            write_reg(pss_zc_pkg::CFG_RECEIVE_MODE, 12'd0);
          end
          5: begin
            write_reg(pss_zc_pkg::CFG_CELL_IDENTITY, 12'd2);
            write_reg(pss_zc_pkg::CFG_FFT_SIZE, 12'd0);
            write_reg(pss_zc_pkg::CFG_RECEIVE_MODE, 12'd1);
          end
          6: begin
            write_reg(pss_zc_pkg::CFG_CELL_IDENTITY, 12'd1);
            write_reg(pss_zc_pkg::CFG_FFT_SIZE, 12'd31);
            write_reg(pss_zc_pkg::CFG_RECEIVE_MODE, 12'd0);
          end
          default: begin
            write_reg(pss_zc_pkg::CFG_CELL_IDENTITY, 12'($urandom_range(0, 3)));
            write_reg(pss_zc_pkg::CFG_FFT_SIZE, ($urandom_range(0, 3) == 0) ?
                      12'($urandom_range(0, 4095)) : 12'($urandom_range(128, 2048)));
            write_reg(pss_zc_pkg::CFG_RECEIVE_MODE, 12'($urandom_range(0, 1)));
          end
        endcase
      end else begin
        foreach (directed[i]) begin
          pending_bins.push_back(directed[i]);
        end
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
        pending_bins.push_back(pick_bin());
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
